// File: src/a64bsd_pkg.sv
// a64bsd_pkg: instruction codes, status codes, encoding masks and the decode
// function for the branch / exception / system decoder
// depends on nothing; imported by arm64_branch_system_decoder_unit and tb_top
package a64bsd_pkg;

  // result status
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNSUP   = 2'd1,
    ST_UNALLOC = 2'd2
  } status_e;

  // instruction ids
  typedef enum logic [4:0] {
    IC_B, IC_BL, IC_CBZ, IC_CBNZ, IC_TBZ, IC_TBNZ, IC_BCOND,
    IC_SVC, IC_HVC, IC_SMC, IC_BRK, IC_HLT, IC_DC_ZVA,
    IC_NOP, IC_YIELD, IC_WFE, IC_WFI, IC_SEV, IC_SEVL, IC_PACIASP, IC_BTI,
    IC_CLREX, IC_DSB, IC_DMB, IC_ISB, IC_MSR_REG, IC_MRS,
    IC_BR, IC_BLR, IC_RET, IC_ERET, IC_DRPS
  } inst_code_e;

  // operand widths
  localparam logic [6:0] WIDTH_32 = 7'd32;
  localparam logic [6:0] WIDTH_64 = 7'd64;

  // class masks and match values
  localparam logic [31:0] M_BIMM     = 32'h7C00_0000;
  localparam logic [31:0] V_BIMM     = 32'h1400_0000;
  localparam logic [31:0] M_CBTB     = 32'h7E00_0000;
  localparam logic [31:0] V_CB       = 32'h3400_0000;
  localparam logic [31:0] V_TB       = 32'h3600_0000;
  localparam logic [31:0] M_EXC      = 32'hFFE0_001F;
  localparam logic [31:0] M_DCZVA    = 32'hFFFF_FFE0;
  localparam logic [31:0] V_DCZVA    = 32'hD50B_7420;
  localparam logic [31:0] M_HINT     = 32'hFFFF_F01F;
  localparam logic [31:0] V_HINT     = 32'hD503_201F;
  localparam logic [31:0] M_BARRIER  = 32'hFFFF_F0FF;
  localparam logic [31:0] M_SYSMOVE  = 32'hFFF0_0000;
  localparam logic [31:0] M_BRREG    = 32'hFFFF_FC1F;
  localparam logic [31:0] W_ERET     = 32'hD69F_03E0;
  localparam logic [31:0] W_DRPS     = 32'hD6BF_03E0;
  localparam logic [3:0]  CRM_SY     = 4'hF;

  // per-instruction match values under the class masks
  localparam logic [31:0] P_SVC   = 32'hD400_0001;
  localparam logic [31:0] P_HVC   = 32'hD400_0002;
  localparam logic [31:0] P_SMC   = 32'hD400_0003;
  localparam logic [31:0] P_BRK   = 32'hD420_0000;
  localparam logic [31:0] P_HLT   = 32'hD440_0000;
  localparam logic [31:0] P_CLREX = 32'hD503_305F;
  localparam logic [31:0] P_DSB   = 32'hD503_309F;
  localparam logic [31:0] P_DMB   = 32'hD503_30BF;
  localparam logic [31:0] P_ISB   = 32'hD503_30DF;
  localparam logic [31:0] P_MSR   = 32'hD510_0000;
  localparam logic [31:0] P_MRS   = 32'hD530_0000;
  localparam logic [31:0] P_BR    = 32'hD61F_0000;
  localparam logic [31:0] P_BLR   = 32'hD63F_0000;
  localparam logic [31:0] P_RET   = 32'hD65F_0000;

  // top-byte groups
  localparam logic [7:0] TOP_BCOND = 8'h54;
  localparam logic [7:0] TOP_EXC   = 8'hD4;
  localparam logic [7:0] TOP_SYS   = 8'hD5;
  localparam logic [7:0] TOP_BRREG = 8'hD6;

  // one decoded result
  typedef struct packed {
    status_e            status;
    inst_code_e         code;
    logic signed [27:0] offset;
    logic [6:0]         width;
    logic [4:0]         rt;
    logic [4:0]         rn;
    logic [15:0]        imm;
    logic [3:0]         cond;
    logic [15:0]        sysreg;
  } dec_res_t;

  // full decode of one instruction word
  function automatic dec_res_t decode_word(input logic [31:0] w);
    dec_res_t   r;
    logic       hit;
    logic [6:0] h;
    logic [3:0] crm;
    r      = '0;
    r.status = ST_UNSUP;
    hit    = 1'b0;
    h      = w[11:5];
    crm    = w[11:8];

    // immediate branches
    if ((w & M_BIMM) == V_BIMM) begin
      hit      = 1'b1;
      r.code   = w[31] ? IC_BL : IC_B;
      r.offset = {w[25:0], 2'b00};
    end else if ((w & M_CBTB) == V_CB) begin
      hit      = 1'b1;
      r.code   = w[24] ? IC_CBNZ : IC_CBZ;
      r.width  = w[31] ? WIDTH_64 : WIDTH_32;
      r.rt     = w[4:0];
      r.offset = {{7{w[23]}}, w[23:5], 2'b00};
    end else if ((w & M_CBTB) == V_TB) begin
      hit      = 1'b1;
      r.code   = w[24] ? IC_TBNZ : IC_TBZ;
      r.width  = w[31] ? WIDTH_64 : WIDTH_32;
      r.rt     = w[4:0];
      r.imm    = {10'd0, w[31], w[23:19]};
      r.offset = {{12{w[18]}}, w[18:5], 2'b00};
    end else if (w[31:24] == TOP_BCOND) begin
      // conditional branch needs bit 4 clear
      if (!w[4]) begin
        hit      = 1'b1;
        r.code   = IC_BCOND;
        r.cond   = w[3:0];
        r.offset = {{7{w[23]}}, w[23:5], 2'b00};
      end
    end else if (w[31:24] == TOP_EXC) begin
      // exception generation
      hit   = 1'b1;
      r.imm = w[20:5];
      case (w & M_EXC)
        P_SVC:   r.code = IC_SVC;
        P_HVC:   r.code = IC_HVC;
        P_SMC:   r.code = IC_SMC;
        P_BRK:   r.code = IC_BRK;
        P_HLT:   r.code = IC_HLT;
        default: hit = 1'b0;
      endcase
    end else if (w[31:24] == TOP_SYS) begin
      if ((w & M_DCZVA) == V_DCZVA) begin
        hit     = 1'b1;
        r.code  = IC_DC_ZVA;
        r.rt    = w[4:0];
        r.width = WIDTH_64;
      end else if ((w & M_HINT) == V_HINT) begin
        // hint space
        hit = 1'b1;
        if (h <= 7'd5) begin
          r.code = inst_code_e'(5'(IC_NOP) + h[4:0]);
        end else if (h == 7'h19) begin
          r.code = IC_PACIASP;
        end else if (h inside {7'h20, 7'h22, 7'h24, 7'h26}) begin
          r.code = IC_BTI;
          r.imm  = {13'd0, h[2:0]};
        end else begin
          hit = 1'b0;
        end
      end else begin
        // barriers, then system register moves
        hit = 1'b1;
        case (w & M_BARRIER)
          P_CLREX: begin
            r.code = IC_CLREX;
            r.imm  = {12'd0, crm};
          end
          P_DSB: begin
            r.code = IC_DSB;
            r.imm  = {12'd0, crm};
          end
          P_DMB: begin
            r.code = IC_DMB;
            r.imm  = {12'd0, crm};
          end
          P_ISB: begin
            if (crm != CRM_SY) begin
              hit      = 1'b0;
              r.status = ST_UNALLOC;
            end else begin
              r.code = IC_ISB;
              r.imm  = {12'd0, CRM_SY};
            end
          end
          default: begin
            r.rt     = w[4:0];
            r.sysreg = w[20:5];
            r.width  = WIDTH_64;
            case (w & M_SYSMOVE)
              P_MSR:   r.code = IC_MSR_REG;
              P_MRS:   r.code = IC_MRS;
              default: hit = 1'b0;
            endcase
          end
        endcase
      end
    end else if (w[31:24] == TOP_BRREG) begin
      // register branches and exception returns
      hit = 1'b1;
      case (w & M_BRREG)
        P_BR:  r.code = IC_BR;
        P_BLR: r.code = IC_BLR;
        P_RET: r.code = IC_RET;
        default: begin
          if (w == W_ERET) begin
            r.code = IC_ERET;
          end else if (w == W_DRPS) begin
            r.code = IC_DRPS;
          end else begin
            hit = 1'b0;
          end
        end
      endcase
      if (r.code == IC_BR || r.code == IC_BLR || r.code == IC_RET) begin
        r.rn    = w[9:5];
        r.width = WIDTH_64;
      end
    end

    // anything not ok carries only its status
    if (hit) begin
      r.status = ST_OK;
    end else begin
      r        = '{status: r.status, code: IC_B, default: '0};
    end
    return r;
  endfunction

endpackage

// File: src/arm64_branch_system_decoder_unit.sv
// arm64_branch_system_decoder_unit: two-register decode pipeline for the
// branch, exception and system instruction class; uses a64bsd_pkg
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+------------------------------------
//   in      | in_valid_i  | in_stall_o  | instr_word_i
//   out     | out_valid_o | out_stall_i | status_o .. sysreg_num_o
//
// one word accepted per cycle when the output side is not stalling
// an accepted word passes through the input register, then the result register, to the output
// the decode sits between the input register and the result register
// reset clears both valid bits; payload registers are not reset
// a stall on the output holds each full stage that cannot drain and reaches in_stall_o directly
module arm64_branch_system_decoder_unit
  import a64bsd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        instr_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [4:0]         inst_code_o,
  output logic signed [27:0] branch_offset_o,
  output logic [6:0]         op_width_o,
  output logic [4:0]         reg_t_o,
  output logic [4:0]         reg_n_o,
  output logic [15:0]        imm_value_o,
  output logic [3:0]         cond_code_o,
  output logic [15:0]        sysreg_num_o
);

  logic        in_valid_q;
  logic [31:0] word_q;
  logic        out_valid_q;
  dec_res_t    res_d;
  dec_res_t    res_q;
  logic        out_adv;
  logic        in_adv;

  // stage advance
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_adv     = !in_valid_q || out_adv;
  assign in_stall_o = !in_adv;

  // decode logic
  assign res_d = decode_word(word_q);

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_adv) begin
        in_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_adv && in_valid_i) begin
      word_q <= instr_word_i;
    end
    if (out_adv && in_valid_q) begin
      res_q <= res_d;
    end
  end

  // outputs
  assign out_valid_o     = out_valid_q;
  assign status_o        = res_q.status;
  assign inst_code_o     = res_q.code;
  assign branch_offset_o = res_q.offset;
  assign op_width_o      = res_q.width;
  assign reg_t_o         = res_q.rt;
  assign reg_n_o         = res_q.rn;
  assign imm_value_o     = res_q.imm;
  assign cond_code_o     = res_q.cond;
  assign sysreg_num_o    = res_q.sysreg;

  // a stall on the input only when both stages are full and the output stalls
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a full pipeline");

  // a result appears only after a word sat in the input register
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result without a decoded word");

  // a failed decode carries nothing but its status
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |->
      (inst_code_o == 5'd0 && branch_offset_o == 28'sd0 && op_width_o == 7'd0 &&
       reg_t_o == 5'd0 && reg_n_o == 5'd0 && imm_value_o == 16'd0 &&
       cond_code_o == 4'd0 && sysreg_num_o == 16'd0))
    else $error("fields set on a failed decode");

  // operand width is one of the legal sizes
  a_width_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (op_width_o == 7'd0 || op_width_o == WIDTH_32 ||
                     op_width_o == WIDTH_64))
    else $error("illegal operand width");

endmodule

// File: bench/tb_top.sv
// tb_top: self-checking bench for the branch / exception / system decoder;
// directed table of words first, then weighted random words with idle and stall
// depends on a64bsd_pkg and arm64_branch_system_decoder_unit
module tb_top
  import a64bsd_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 750;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [31:0]        instr_word_i = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic [1:0]         status_o;
  logic [4:0]         inst_code_o;
  logic signed [27:0] branch_offset_o;
  logic [6:0]         op_width_o;
  logic [4:0]         reg_t_o;
  logic [4:0]         reg_n_o;
  logic [15:0]        imm_value_o;
  logic [3:0]         cond_code_o;
  logic [15:0]        sysreg_num_o;

  typedef struct {
    logic [31:0] word;
    bit          typed;
    dec_res_t    exp;
  } stim_row_t;

  dec_res_t  pending_decodes[$];
  stim_row_t stim_rows[$];
  bit        gaps_on   = 1'b0;
  bit        stalls_on = 1'b0;
  int        n_errors  = 0;
  int        n_checked = 0;
  int        n_sent    = 0;

  arm64_branch_system_decoder_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .instr_word_i   (instr_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .inst_code_o    (inst_code_o),
    .branch_offset_o(branch_offset_o),
    .op_width_o     (op_width_o),
    .reg_t_o        (reg_t_o),
    .reg_n_o        (reg_n_o),
    .imm_value_o    (imm_value_o),
    .cond_code_o    (cond_code_o),
    .sysreg_num_o   (sysreg_num_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // expected decode of one instruction word
  function automatic dec_res_t predict_decode(input logic [31:0] w);
    dec_res_t   r;
    logic       ok;
    logic [6:0] hint;
    logic [3:0] crm;
    status_e    st;
    r        = '0;
    r.status = ST_UNSUP;
    ok       = 1'b1;
    hint     = w[11:5];
    crm      = w[11:8];
    if (w[30:26] == 5'b00101) begin
      r.code   = w[31] ? IC_BL : IC_B;
      r.offset = {w[25:0], 2'b00};
    end else if (w[30:25] == 6'b011010 || w[30:25] == 6'b011011) begin
      // compare and test branches share width and rt
      r.width = w[31] ? WIDTH_64 : WIDTH_32;
      r.rt    = w[4:0];
      if (!w[25]) begin
        r.code   = w[24] ? IC_CBNZ : IC_CBZ;
        r.offset = {{7{w[23]}}, w[23:5], 2'b00};
      end else begin
        r.code   = w[24] ? IC_TBNZ : IC_TBZ;
        r.imm    = {10'd0, w[31], w[23:19]};
        r.offset = {{12{w[18]}}, w[18:5], 2'b00};
      end
    end else begin
      case (w[31:24])
        TOP_BCOND: begin
          if (w[4]) begin
            ok = 1'b0;
          end else begin
            r.code   = IC_BCOND;
            r.cond   = w[3:0];
            r.offset = {{7{w[23]}}, w[23:5], 2'b00};
          end
        end
        TOP_EXC: begin
          r.imm = w[20:5];
          case (w & M_EXC)
            P_SVC:   r.code = IC_SVC;
            P_HVC:   r.code = IC_HVC;
            P_SMC:   r.code = IC_SMC;
            P_BRK:   r.code = IC_BRK;
            P_HLT:   r.code = IC_HLT;
            default: ok = 1'b0;
          endcase
        end
        TOP_SYS: begin
          if ((w & M_DCZVA) == V_DCZVA) begin
            r.code  = IC_DC_ZVA;
            r.rt    = w[4:0];
            r.width = WIDTH_64;
          end else if ((w & M_HINT) == V_HINT) begin
            case (hint)
              7'h00: r.code = IC_NOP;
              7'h01: r.code = IC_YIELD;
              7'h02: r.code = IC_WFE;
              7'h03: r.code = IC_WFI;
              7'h04: r.code = IC_SEV;
              7'h05: r.code = IC_SEVL;
              7'h19: r.code = IC_PACIASP;
              7'h20, 7'h22, 7'h24, 7'h26: begin
                r.code = IC_BTI;
                r.imm  = 16'(hint - 7'h20);
              end
              default: ok = 1'b0;
            endcase
          end else begin
            case (w & M_BARRIER)
              P_CLREX: begin
                r.code = IC_CLREX;
                r.imm  = 16'(crm);
              end
              P_DSB: begin
                r.code = IC_DSB;
                r.imm  = 16'(crm);
              end
              P_DMB: begin
                r.code = IC_DMB;
                r.imm  = 16'(crm);
              end
              P_ISB: begin
                // isb only with the full-system option
                if (crm != CRM_SY) begin
                  ok       = 1'b0;
                  r.status = ST_UNALLOC;
                end else begin
                  r.code = IC_ISB;
                  r.imm  = 16'(CRM_SY);
                end
              end
              default: begin
                r.rt     = w[4:0];
                r.sysreg = w[20:5];
                r.width  = WIDTH_64;
                if ((w & M_SYSMOVE) == P_MSR) begin
                  r.code = IC_MSR_REG;
                end else if ((w & M_SYSMOVE) == P_MRS) begin
                  r.code = IC_MRS;
                end else begin
                  ok = 1'b0;
                end
              end
            endcase
          end
        end
        TOP_BRREG: begin
          case (w & M_BRREG)
            P_BR, P_BLR, P_RET: begin
              r.code  = ((w & M_BRREG) == P_BR)  ? IC_BR :
                        ((w & M_BRREG) == P_BLR) ? IC_BLR : IC_RET;
              r.rn    = w[9:5];
              r.width = WIDTH_64;
            end
            default: begin
              if (w == W_ERET) begin
                r.code = IC_ERET;
              end else if (w == W_DRPS) begin
                r.code = IC_DRPS;
              end else begin
                ok = 1'b0;
              end
            end
          endcase
        end
        default: ok = 1'b0;
      endcase
    end
    // a rejected word keeps only its status
    if (ok) begin
      r.status = ST_OK;
    end else begin
      st       = r.status;
      r        = '0;
      r.status = st;
    end
    return r;
  endfunction

  // hand-written result with only status, code and offset set
  function automatic dec_res_t typed_result(input status_e s, input inst_code_e c,
                                            input logic [27:0] off);
    dec_res_t r;
    r        = '0;
    r.status = s;
    r.code   = c;
    r.offset = off;
    return r;
  endfunction

  // word from one of the decode classes, random content, some noise
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    logic [6:0]  h;
    logic [3:0]  crm;
    w = $urandom();
    case ($urandom_range(0, 19))
      0, 1: w[30:26] = 5'b00101;
      2, 3: w[30:25] = 6'b011010;
      4, 5: w[30:25] = 6'b011011;
      6: begin
        w[31:24] = TOP_BCOND;
        if ($urandom_range(0, 4) != 0) w[4] = 1'b0;
      end
      7, 8: begin
        w = w & ~M_EXC;
        case ($urandom_range(0, 4))
          0: w = w | P_SVC;
          1: w = w | P_HVC;
          2: w = w | P_SMC;
          3: w = w | P_BRK;
          default: w = w | P_HLT;
        endcase
        // occasionally break the low opcode bits
        if ($urandom_range(0, 5) == 0) w[4:0] = 5'($urandom());
      end
      9: w = V_DCZVA | {27'd0, w[4:0]};
      10, 11: begin
        case ($urandom_range(0, 3))
          0: h = 7'($urandom_range(0, 5));
          1: h = 7'h19;
          2: h = 7'(7'h20 + 2 * $urandom_range(0, 3));
          default: h = 7'($urandom());
        endcase
        w = V_HINT | {20'd0, h, 5'd0};
      end
      12, 13: begin
        crm = $urandom_range(0, 1) ? CRM_SY : 4'($urandom());
        case ($urandom_range(0, 3))
          0: w = P_CLREX;
          1: w = P_DSB;
          2: w = P_DMB;
          default: w = P_ISB;
        endcase
        w = w | {20'd0, crm, 8'd0};
      end
      14, 15: begin
        if ($urandom_range(0, 4) == 0) begin
          w[31:24] = TOP_SYS;
        end else begin
          w = ($urandom_range(0, 1) ? P_MSR : P_MRS) | {12'd0, w[19:0]};
        end
      end
      16, 17: begin
        case ($urandom_range(0, 5))
          0: w = P_BR  | {22'd0, w[9:5], 5'd0};
          1: w = P_BLR | {22'd0, w[9:5], 5'd0};
          2: w = P_RET | {22'd0, w[9:5], 5'd0};
          3: w = W_ERET;
          4: w = W_DRPS;
          default: w[31:24] = TOP_BRREG;
        endcase
      end
      default: ;
    endcase
    return w;
  endfunction

  // present one word, optionally after idle cycles, and log its expectation
  task automatic send_word(input logic [31:0] w, input dec_res_t e);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(0, 99) < 25) begin
      in_valid_i   <= 1'b0;
      instr_word_i <= $urandom();
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    instr_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    pending_decodes.push_back(e);
    n_sent++;
  endtask

  // stop sending until every expected result has come out
  task automatic drain_decoder();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_decodes.size() != 0) @(negedge clk_i);
  endtask

  task automatic add_row(input logic [31:0] w);
    stim_row_t row;
    row.word  = w;
    row.typed = 1'b0;
    row.exp   = '0;
    stim_rows.push_back(row);
  endtask

  task automatic add_typed(input logic [31:0] w, input dec_res_t e);
    stim_row_t row;
    row.word  = w;
    row.typed = 1'b1;
    row.exp   = e;
    stim_rows.push_back(row);
  endtask

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (a !== e) begin
      n_errors++;
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, e, a);
    end
  endtask

  // output stall, random while enabled
  always @(negedge clk_i) begin
    out_stall_i <= stalls_on && ($urandom_range(0, 99) < 25);
  end

  // compare each delivered word with the oldest expectation
  always @(posedge clk_i) begin
    dec_res_t e;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pending_decodes.size() == 0) begin
        n_errors++;
        $display("%0t ns: result with nothing expected, status %h code %h",
                 $time, status_o, inst_code_o);
      end else begin
        e = pending_decodes.pop_front();
        n_checked++;
        check_field("status", 32'(e.status), 32'(status_o));
        check_field("inst_code", 32'(e.code), 32'(inst_code_o));
        check_field("branch_offset", 32'(unsigned'(e.offset)),
                    32'(unsigned'(branch_offset_o)));
        check_field("op_width", 32'(e.width), 32'(op_width_o));
        check_field("reg_t", 32'(e.rt), 32'(reg_t_o));
        check_field("reg_n", 32'(e.rn), 32'(reg_n_o));
        check_field("imm_value", 32'(e.imm), 32'(imm_value_o));
        check_field("cond_code", 32'(e.cond), 32'(cond_code_o));
        check_field("sysreg_num", 32'(e.sysreg), 32'(sysreg_num_o));
      end
    end
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("%0t ns: timeout with %0d results outstanding", $time, pending_decodes.size());
    $display("*** FAILED ***");
    $finish;
  end

  // main sequence
  initial begin
    logic [31:0] w;
    int          n_directed;

    // results that are plain to see
    add_typed(32'h0000_0000, typed_result(ST_UNSUP, IC_B, 28'h0));
    add_typed(32'hFFFF_FFFF, typed_result(ST_UNSUP, IC_B, 28'h0));
    add_typed(32'h15FF_FFFF, typed_result(ST_OK, IC_B, 28'h7FF_FFFC));
    add_typed(32'h9600_0000, typed_result(ST_OK, IC_BL, 28'h800_0000));
    add_typed(32'h5400_0010, typed_result(ST_UNSUP, IC_B, 28'h0));
    add_typed(32'hD503_30DF, typed_result(ST_UNALLOC, IC_B, 28'h0));
    add_typed(W_ERET, typed_result(ST_OK, IC_ERET, 28'h0));
    add_typed(W_DRPS, typed_result(ST_OK, IC_DRPS, 28'h0));
    add_typed(V_HINT, typed_result(ST_OK, IC_NOP, 28'h0));
    // every other operation, checked by the predictor
    add_row(32'h3480_0005);  // cbz, 32-bit, negative offset
    add_row(32'hB500_0FFF);  // cbnz, 64-bit
    add_row(32'h3600_0000);  // tbz, bit 0
    add_row(32'hB7FF_FFFF);  // tbnz, bit 63, negative offset
    add_row(32'h54FF_FFEF);  // b.cond, cond 15
    add_row(32'hD41F_FFE1);  // svc, imm16 all ones
    add_row(P_HVC);
    add_row(P_SMC);
    add_row(P_BRK);
    add_row(32'hD45F_FFE0);  // hlt, imm16 all ones
    add_row(32'hD50B_743F);
    add_row(32'hD503_203F);
    add_row(32'hD503_205F);
    add_row(32'hD503_207F);
    add_row(32'hD503_209F);
    add_row(32'hD503_20BF);
    add_row(32'hD503_233F);  // paciasp
    add_row(32'hD503_249F);  // bti target 4
    add_row(32'hD503_20DF);  // hint with no meaning
    add_row(32'hD503_3F5F);
    add_row(32'hD503_3F9F);
    add_row(32'hD503_35BF);
    add_row(32'hD503_3FDF);  // isb sy
    add_row(32'hD51B_4221);
    add_row(32'hD53B_E03F);
    add_row(32'hD61F_0020);
    add_row(32'hD63F_03C0);
    add_row(32'hD65F_03C0);
    add_row(32'hD61F_0001);  // register branch with stray rm bits

    // reset
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part, back to back
    foreach (stim_rows[i]) begin
      send_word(stim_rows[i].word,
                stim_rows[i].typed ? stim_rows[i].exp : predict_decode(stim_rows[i].word));
    end
    n_directed = n_sent;
    drain_decoder();

    // random part
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // quiet stretch with neither side idling
      gaps_on   = !(i >= 200 && i < 350);
      stalls_on = gaps_on;
      if (i == 500) drain_decoder();
      w = random_word();
      send_word(w, predict_decode(w));
    end

    drain_decoder();
    stalls_on = 1'b0;
    repeat (10) @(posedge clk_i);

    $display("sent %0d words (%0d directed, %0d random), checked %0d results, %0d mismatches",
             n_sent, n_directed, n_sent - n_directed, n_checked, n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
